// File: rtl/bvd_pkg.sv
// ----------------------------------------------------------------------------
// bvd_pkg
// Shared types and constants for the bf16 vector distance unit.
// ----------------------------------------------------------------------------
package bvd_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO   = 32'h0000_0000;
    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam int          WIDEN_SHIFT = 16;

    localparam logic [1:0] MET_NORM = 2'd0;
    localparam logic [1:0] MET_DOT  = 2'd1;
    localparam logic [1:0] MET_L2SQ = 2'd2;
    localparam logic [1:0] MET_COS  = 2'd3;

    localparam logic CFG_METRIC = 1'b0;
    localparam logic CFG_QNORM  = 1'b1;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_ADDD,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_fop;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ITER,
        F_ROUND
    } t_fstate;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        K_DIFF,
        K_PROD,
        K_ACC,
        K_YSQ,
        K_YACC,
        K_ROOT,
        K_DEN,
        K_QUO,
        K_ONE
    } t_step;

    function automatic logic [31:0] f_canon(input logic [31:0] v);
        if (&v[30:23] && |v[22:0]) begin
            return CANON_NAN;
        end
        return v;
    endfunction

endpackage

// File: rtl/bvd_fpu.sv
// ----------------------------------------------------------------------------
// bvd_fpu
// Shared fp32 unit: add, add with binary64 intermediate rounding, multiply,
// bit-serial divide and bit-serial square root, round to nearest even.
// ----------------------------------------------------------------------------
module bvd_fpu (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bvd_pkg::t_fop    i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic             o_done,
    output logic [31:0]      o_res
);
    import bvd_pkg::*;

    function automatic logic signed [11:0] f_exp(input logic [31:0] v);
        if (v[30:23] == 8'd0) begin
            return -12'sd126;
        end
        return $signed({4'b0, v[30:23]}) - 12'sd127;
    endfunction

    function automatic logic [4:0] f_lz24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = '0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] f_lz57(input logic [56:0] v);
        logic [5:0] n;
        logic       found;
        n = '0;
        found = 1'b0;
        for (int i = 56; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] f_round(input logic s, input logic signed [11:0] e,
                                            input logic [56:0] n, input logic dbl);
        logic [5:0]         lz;
        logic [56:0]        n1;
        logic [56:0]        n2;
        logic signed [11:0] e1;
        logic [53:0]        k;
        logic [11:0]        sh;
        logic               lost;
        logic [7:0]         bexp;
        logic [23:0]        m;
        logic               inc;
        logic [30:0]        pk;
        lz = f_lz57(n);
        n1 = n << lz;
        e1 = e - $signed({6'b0, lz});
        if (dbl) begin
            k = {1'b0, n1[56:4]} + {53'b0, n1[3] & ((|n1[2:0]) | n1[4])};
            if (k[53]) begin
                n1 = {1'b1, 56'b0};
                e1 = e1 + 12'sd1;
            end else begin
                n1 = {k[52:0], 4'b0};
            end
        end
        if (e1 < -12'sd126) begin
            sh = 12'(-12'sd126 - e1);
            n2 = n1 >> sh;
            lost = (n2 << sh) != n1;
            n2[0] = n2[0] | lost;
            bexp = 8'd0;
        end else begin
            n2 = n1;
            bexp = 8'(e1 + 12'sd127);
        end
        m = n2[56:33];
        inc = n2[32] & ((|n2[31:0]) | m[0]);
        pk = {bexp, m[22:0]} + {30'b0, inc};
        if (e1 > 12'sd127) begin
            pk = {8'hFF, 23'b0};
        end
        return {s, pk};
    endfunction

    t_fstate            r_state, n_state;
    t_fop               r_op, n_op;
    logic               r_spec, n_spec;
    logic [31:0]        r_spec_val, n_spec_val;
    logic               r_sign, n_sign;
    logic signed [11:0] r_exp, n_exp;
    logic [56:0]        r_n, n_n;
    logic [4:0]         r_cnt, n_cnt;
    logic [27:0]        r_rem, n_rem;
    logic [23:0]        r_dvs, n_dvs;
    logic [26:0]        r_q, n_q;
    logic [24:0]        r_root, n_root;
    logic [49:0]        r_rad, n_rad;

    // operand unpack
    logic               sa, sb, za, zb, ia, ib, qa, qb;
    logic signed [11:0] ea, eb;
    logic [23:0]        ma, mb;
    assign sa = i_a[31];
    assign sb = i_b[31];
    assign ea = f_exp(i_a);
    assign eb = f_exp(i_b);
    assign ma = {|i_a[30:23], i_a[22:0]};
    assign mb = {|i_b[30:23], i_b[22:0]};
    assign za = i_a[30:0] == 31'd0;
    assign zb = i_b[30:0] == 31'd0;
    assign ia = (&i_a[30:23]) && (i_a[22:0] == 23'd0);
    assign ib = (&i_b[30:23]) && (i_b[22:0] == 23'd0);
    assign qa = (&i_a[30:23]) && (|i_a[22:0]);
    assign qb = (&i_b[30:23]) && (|i_b[22:0]);

    // add alignment
    logic               swap, sl;
    logic signed [11:0] el, es;
    logic [23:0]        ml, ms;
    logic [8:0]         ad;
    logic [56:0]        abig, afull, ash, asml, asum;
    logic               alost;
    assign swap  = i_b[30:0] > i_a[30:0];
    assign sl    = swap ? sb : sa;
    assign el    = swap ? eb : ea;
    assign es    = swap ? ea : eb;
    assign ml    = swap ? mb : ma;
    assign ms    = swap ? ma : mb;
    assign ad    = 9'(el - es);
    assign abig  = {1'b0, ml, 32'b0};
    assign afull = {1'b0, ms, 32'b0};
    assign ash   = afull >> ad;
    assign alost = (ash << ad) != afull;
    assign asml  = ash | {56'b0, alost};
    assign asum  = (sa == sb) ? abig + asml : abig - asml;

    // multiply
    logic [47:0] mp;
    assign mp = ma * mb;

    // divide and square root operand normalization
    logic [4:0]         lza, lzb;
    logic [23:0]        dna, dnb;
    logic signed [11:0] dea, deb, sqe;
    logic [24:0]        sqm;
    assign lza = f_lz24(ma);
    assign lzb = f_lz24(mb);
    assign dna = ma << lza;
    assign dnb = mb << lzb;
    assign dea = ea - $signed({7'b0, lza});
    assign deb = eb - $signed({7'b0, lzb});
    assign sqe = dea[0] ? dea - 12'sd1 : dea;
    assign sqm = dea[0] ? {dna, 1'b0} : {1'b0, dna};

    // iteration
    logic        dge;
    logic [25:0] drem;
    logic [26:0] dq;
    logic [27:0] srem, strial;
    logic        sge;
    assign dge    = r_rem[25:0] >= {2'b0, r_dvs};
    assign drem   = (dge ? r_rem[25:0] - {2'b0, r_dvs} : r_rem[25:0]) << 1;
    assign dq     = {r_q[25:0], dge};
    assign srem   = {r_rem[25:0], r_rad[49:48]};
    assign strial = {1'b0, r_root, 2'b01};
    assign sge    = srem >= strial;

    // result
    logic [23:0] sq_q;
    logic        sq_inc;
    logic [7:0]  sq_exp;
    logic [31:0] sq_res;
    assign sq_q   = r_root[24:1];
    assign sq_inc = r_root[0] & ((r_rem != 28'd0) | sq_q[0]);
    assign sq_exp = 8'((r_exp >>> 1) + 12'sd127);
    assign sq_res = {1'b0, sq_exp, sq_q[22:0]} + {31'b0, sq_inc};

    always_comb begin
        o_done = r_state == F_ROUND;
        if (r_spec) begin
            o_res = r_spec_val;
        end else if (r_op == OP_SQRT) begin
            o_res = sq_res;
        end else begin
            o_res = f_round(r_sign, r_exp, r_n, r_op == OP_ADDD);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_spec     = r_spec;
        n_spec_val = r_spec_val;
        n_sign     = r_sign;
        n_exp      = r_exp;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_q        = r_q;
        n_root     = r_root;
        n_rad      = r_rad;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_op       = i_op;
                    n_spec     = 1'b0;
                    n_spec_val = CANON_NAN;
                    n_state    = F_ROUND;
                    unique case (i_op)
                        OP_ADD, OP_ADDD: begin
                            n_sign = sl;
                            n_exp  = el + 12'sd1;
                            n_n    = asum;
                            if (qa || qb || (ia && ib && sa != sb)) begin
                                n_spec = 1'b1;
                            end else if (ia) begin
                                n_spec = 1'b1;
                                n_spec_val = i_a;
                            end else if (ib) begin
                                n_spec = 1'b1;
                                n_spec_val = i_b;
                            end else if (asum == 57'd0) begin
                                n_spec = 1'b1;
                                n_spec_val = {sa & sb, 31'b0};
                            end
                        end
                        OP_MUL: begin
                            n_sign = sa ^ sb;
                            n_exp  = ea + eb + 12'sd1;
                            n_n    = {mp, 9'b0};
                            if (qa || qb || (ia && zb) || (za && ib)) begin
                                n_spec = 1'b1;
                            end else if (ia || ib) begin
                                n_spec = 1'b1;
                                n_spec_val = {sa ^ sb, 8'hFF, 23'b0};
                            end else if (za || zb) begin
                                n_spec = 1'b1;
                                n_spec_val = {sa ^ sb, 31'b0};
                            end
                        end
                        OP_DIV: begin
                            n_sign = sa ^ sb;
                            n_exp  = dea - deb;
                            if (qa || qb || (ia && ib) || (za && zb)) begin
                                n_spec = 1'b1;
                            end else if (ia || zb) begin
                                n_spec = 1'b1;
                                n_spec_val = {sa ^ sb, 8'hFF, 23'b0};
                            end else if (za || ib) begin
                                n_spec = 1'b1;
                                n_spec_val = {sa ^ sb, 31'b0};
                            end else begin
                                n_state = F_ITER;
                                n_cnt   = 5'd26;
                                n_rem   = {4'b0, dna};
                                n_dvs   = dnb;
                                n_q     = '0;
                            end
                        end
                        OP_SQRT: begin
                            n_exp = sqe;
                            if (za || (ia && !sa)) begin
                                n_spec = 1'b1;
                                n_spec_val = i_a;
                            end else if (qa || sa) begin
                                n_spec = 1'b1;
                            end else begin
                                n_state = F_ITER;
                                n_cnt   = 5'd24;
                                n_rem   = '0;
                                n_root  = '0;
                                n_rad   = {sqm, 25'b0};
                            end
                        end
                        default: begin
                            n_spec = 1'b1;
                        end
                    endcase
                end
            end
            F_ITER: begin
                n_cnt = r_cnt - 5'd1;
                if (r_op == OP_DIV) begin
                    n_rem = {2'b0, drem};
                    n_q   = dq;
                    if (r_cnt == 5'd0) begin
                        n_n     = {dq, 30'b0} | {56'b0, drem != 26'd0};
                        n_state = F_ROUND;
                    end
                end else begin
                    n_rem  = sge ? srem - strial : srem;
                    n_root = {r_root[23:0], sge};
                    n_rad  = r_rad << 2;
                    if (r_cnt == 5'd0) begin
                        n_state = F_ROUND;
                    end
                end
            end
            F_ROUND: begin
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op       <= n_op;
        r_spec     <= n_spec;
        r_spec_val <= n_spec_val;
        r_sign     <= n_sign;
        r_exp      <= n_exp;
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_q        <= n_q;
        r_root     <= n_root;
        r_rad      <= n_rad;
    end

endmodule

// File: rtl/bf16_vector_distance_unit.sv
// The stream is accepted only in the idle state, so a new element is taken
// only after the shared unit has finished every operation for the last one.
// The last element adds the bit-serial square root in norm mode, and in
// cosine mode root, multiply, 27-step divide and subtract.
// Synchronous active-low reset: metric 0, query norm 1.0, sums +0, no result.
// ----------------------------------------------------------------------------
// bf16_vector_distance_unit
// Norm, dot, squared distance and cosine distance of bf16 vector pairs with
// fp32 accumulation through one shared floating-point unit.
// ----------------------------------------------------------------------------
module bf16_vector_distance_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // x_elem [15:0], y_elem [31:16]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result_value [31:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bvd_pkg::*;

    t_state      r_state, n_state;
    t_step       r_step, n_step;
    logic [1:0]  r_metric;
    logic [31:0] r_qnorm;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_ysum, n_ysum;
    logic [31:0] r_tmp, n_tmp;
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;

    logic        fpu_start;
    t_fop        fpu_op;
    logic [31:0] fpu_a, fpu_b, fpu_res;
    logic        fpu_done;

    bvd_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fpu_start),
        .i_op    (fpu_op),
        .i_a     (fpu_a),
        .i_b     (fpu_b),
        .o_done  (fpu_done),
        .o_res   (fpu_res)
    );

    assign o_s_tready  = r_state == ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // operand select
    always_comb begin
        fpu_start = r_state == ST_ISSUE;
        fpu_op    = OP_ADD;
        fpu_a     = r_sum;
        fpu_b     = r_tmp;
        unique case (r_step)
            K_DIFF: begin
                fpu_a = r_x;
                fpu_b = r_y ^ SIGN_BIT;
            end
            K_PROD: begin
                fpu_op = OP_MUL;
                fpu_a  = (r_metric == MET_L2SQ) ? r_tmp : r_x;
                if (r_metric == MET_NORM) begin
                    fpu_b = r_x;
                end else if (r_metric == MET_L2SQ) begin
                    fpu_b = r_tmp;
                end else begin
                    fpu_b = r_y;
                end
            end
            K_ACC: begin
                fpu_a = r_sum;
                fpu_b = r_tmp;
            end
            K_YSQ: begin
                fpu_op = OP_MUL;
                fpu_a  = r_y;
                fpu_b  = r_y;
            end
            K_YACC: begin
                fpu_a = r_ysum;
                fpu_b = r_tmp;
            end
            K_ROOT: begin
                fpu_op = OP_SQRT;
                fpu_a  = (r_metric == MET_NORM) ? r_sum : r_ysum;
            end
            K_DEN: begin
                fpu_op = OP_MUL;
                fpu_a  = r_qnorm;
                fpu_b  = r_tmp;
            end
            K_QUO: begin
                fpu_op = OP_DIV;
                fpu_a  = r_sum;
                fpu_b  = r_tmp;
            end
            K_ONE: begin
                fpu_op = OP_ADDD;
                fpu_a  = FP_ONE;
                fpu_b  = r_tmp ^ SIGN_BIT;
            end
            default: begin
                fpu_op = OP_ADD;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sum       = r_sum;
        n_ysum      = r_ysum;
        n_tmp       = r_tmp;
        n_x         = r_x;
        n_y         = r_y;
        n_last      = r_last;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_x     = {i_s_tdata[15:0], 16'b0};
                    n_y     = {i_s_tdata[31:16], 16'b0};
                    n_last  = i_s_tlast;
                    n_step  = (r_metric == MET_L2SQ) ? K_DIFF : K_PROD;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (fpu_done) begin
                    n_state = ST_ISSUE;
                    if (r_step == K_ACC) begin
                        n_sum = fpu_res;
                    end else if (r_step == K_YACC) begin
                        n_ysum = fpu_res;
                    end else begin
                        n_tmp = fpu_res;
                    end
                    unique case (r_step)
                        K_DIFF: n_step = K_PROD;
                        K_PROD: n_step = K_ACC;
                        K_YSQ:  n_step = K_YACC;
                        K_DEN:  n_step = K_QUO;
                        K_QUO:  n_step = K_ONE;
                        K_ONE:  n_state = ST_OUT;
                        K_ROOT: begin
                            if (r_metric == MET_NORM) begin
                                n_state = ST_OUT;
                            end else begin
                                n_step = K_DEN;
                            end
                        end
                        K_ACC, K_YACC: begin
                            if (r_step == K_ACC && r_metric == MET_COS) begin
                                n_step = K_YSQ;
                            end else if (!r_last) begin
                                n_state = ST_IDLE;
                            end else if (r_metric == MET_DOT || r_metric == MET_L2SQ) begin
                                n_tmp   = fpu_res;
                                n_state = ST_OUT;
                            end else begin
                                n_step = K_ROOT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = f_canon(r_tmp);
                    n_sum       = FP_ZERO;
                    n_ysum      = FP_ZERO;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= K_PROD;
            r_metric    <= MET_NORM;
            r_qnorm     <= FP_ONE;
            r_sum       <= FP_ZERO;
            r_ysum      <= FP_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_sum       <= n_sum;
            r_ysum      <= n_ysum;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_METRIC) begin
                    r_metric <= i_cfg_data[1:0];
                end else begin
                    r_qnorm <= i_cfg_data;
                end
            end
        end
        r_tmp      <= n_tmp;
        r_x        <= n_x;
        r_y        <= n_y;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

endmodule

// File: sim/tb_bf16_vector_distance_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bf16_vector_distance_unit
// Self-checking bench for the bf16 vector distance unit. Streams bf16 element
// pairs under every metric and a range of query norms, predicts each fp32
// result with a bit-exact model of the float arithmetic, and compares
// every result transfer in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bf16_vector_distance_unit;
    import bvd_pkg::*;

    localparam int   TARGET_ITEMS = 1400;
    localparam int   SETTLE_CYCLES = 150;
    localparam int   CYCLE_LIMIT = 2_000_000;
    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    bf16_vector_distance_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // fp32 arithmetic, round to nearest even, subnormals kept

    function automatic bit is_nan(logic [31:0] b);
        return (&b[30:23]) && (|b[22:0]);
    endfunction

    function automatic bit is_inf(logic [31:0] b);
        return (&b[30:23]) && !(|b[22:0]);
    endfunction

    function automatic bit is_zero(logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    // value = m * 2^e
    function automatic void fp_split(input logic [31:0] b, output int e,
                                     output logic [127:0] m);
        if (b[30:23] == 8'd0) begin
            m = {105'd0, b[22:0]};
            e = -149;
        end else begin
            m = {104'd0, 1'b1, b[22:0]};
            e = int'(b[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] fp_round(bit sgn, int e, logic [127:0] m);
        int p;
        int s;
        logic [127:0] q;
        logic [127:0] mask;
        bit g;
        bit st;
        logic [63:0] r;
        if (m == 128'd0) return {sgn, 31'd0};
        p = 127;
        while (!m[p]) p--;
        s = p - 23;
        if (-149 - e > s) s = -149 - e;
        if (s <= 0) begin
            q = m << (-s);
            g = 1'b0;
            st = 1'b0;
        end else if (s > 128) begin
            q = 128'd0;
            g = 1'b0;
            st = 1'b1;
        end else begin
            q = m >> s;
            g = m[s-1];
            mask = (128'd1 << (s - 1)) - 128'd1;
            st = |(m & mask);
        end
        if (g && (st || q[0])) q = q + 128'd1;
        r = (64'(s + e + 149) << 23) + q[63:0];
        if (r >= 64'h7F80_0000) return {sgn, 8'hFF, 23'd0};
        return {sgn, r[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        bit sg;
        int ea;
        int eb;
        logic [127:0] ma;
        logic [127:0] mb;
        sg = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return QNAN;
            return {sg, 8'hFF, 23'd0};
        end
        if (is_zero(a) || is_zero(b)) return {sg, 31'd0};
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        return fp_round(sg, ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        int ea;
        int eb;
        int d;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [31:0] t;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        if (a[30:0] < b[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        d = ea - eb;
        if (d > 60) begin
            // far smaller operand only acts as a sticky bit
            ma = ma << 60;
            ea = ea - 60;
            mb = 128'd1;
        end else begin
            ma = ma << d;
            ea = eb;
        end
        if (a[31] == b[31]) return fp_round(a[31], ea, ma + mb);
        if (ma == mb) return 32'd0;
        if (ma > mb) return fp_round(a[31], ea, ma - mb);
        return fp_round(b[31], ea, mb - ma);
    endfunction

    function automatic logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
        bit sg;
        int ea;
        int eb;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] num;
        logic [127:0] quot;
        sg = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a)) return is_inf(b) ? QNAN : {sg, 8'hFF, 23'd0};
        if (is_inf(b)) return {sg, 31'd0};
        if (is_zero(a)) return is_zero(b) ? QNAN : {sg, 31'd0};
        if (is_zero(b)) return {sg, 8'hFF, 23'd0};
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        num = ma << 60;
        quot = num / mb;
        quot = (quot << 1) | ((num % mb) != 128'd0);
        return fp_round(sg, ea - eb - 61, quot);
    endfunction

    function automatic logic [31:0] fp_sqrt(logic [31:0] b);
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] q;
        int e;
        if (is_zero(b)) return b;
        if (is_nan(b) || b[31]) return QNAN;
        if (is_inf(b)) return b;
        if (b[30:23] == 8'd0) begin
            m = {41'd0, b[22:0]};
            e = -126;
            while (m < 64'h80_0000) begin
                m = m << 1;
                e--;
            end
        end else begin
            m = {40'd0, 1'b1, b[22:0]};
            e = int'(b[30:23]) - 127;
        end
        if (e % 2 != 0) begin
            m = m << 1;
            e--;
        end
        n = m << 25;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        q = root >> 1;
        if (root[0] && (n != 64'd0 || q[0])) q = q + 64'd1;
        return 32'((e / 2 + 127) << 23) + q[31:0] - 32'h80_0000;
    endfunction

    // 1 - quo in double precision, then rounded to fp32
    function automatic logic [31:0] one_minus(logic [31:0] quo);
        int e;
        logic [127:0] m;
        real v;
        real dv;
        logic [63:0] db;
        if (is_nan(quo)) return QNAN;
        if (is_inf(quo)) return {~quo[31], 8'hFF, 23'd0};
        if (is_zero(quo)) return FP_ONE;
        fp_split(quo, e, m);
        v = real'(m[31:0]) * (2.0 ** e);
        if (quo[31]) v = -v;
        dv = 1.0 - v;
        if (dv == 0.0) return 32'd0;
        db = $realtobits(dv);
        if (db[62:52] == 11'd0) begin
            m = {76'd0, db[51:0]};
            e = -1074;
        end else begin
            m = {75'd0, 1'b1, db[51:0]};
            e = int'(db[62:52]) - 1075;
        end
        return fp_round(db[63], e, m);
    endfunction

    class dist_scoreboard;
        logic [1:0]  metric;
        logic [31:0] qnorm;
        logic [31:0] acc_sum;
        logic [31:0] ysq_sum;
        logic [31:0] result_q[$];
        int          mismatches;
        int          results_checked;
        int          items_in;

        function new();
            metric = MET_NORM;
            qnorm = FP_ONE;
            acc_sum = FP_ZERO;
            ysq_sum = FP_ZERO;
            mismatches = 0;
            results_checked = 0;
            items_in = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] v);
            if (idx == CFG_METRIC) metric = v[1:0];
            else qnorm = v;
        endfunction

        function void note_input(logic [15:0] xe, logic [15:0] ye, logic last);
            logic [31:0] x;
            logic [31:0] y;
            logic [31:0] d;
            logic [31:0] r;
            x = {xe, 16'd0};
            y = {ye, 16'd0};
            items_in++;
            case (metric)
                MET_NORM: acc_sum = fp_add(acc_sum, fp_mul(x, x));
                MET_DOT:  acc_sum = fp_add(acc_sum, fp_mul(x, y));
                MET_L2SQ: begin
                    d = fp_add(x, {~y[31], y[30:0]});
                    acc_sum = fp_add(acc_sum, fp_mul(d, d));
                end
                default: begin
                    acc_sum = fp_add(acc_sum, fp_mul(x, y));
                    ysq_sum = fp_add(ysq_sum, fp_mul(y, y));
                end
            endcase
            if (!last) return;
            case (metric)
                MET_NORM: r = fp_sqrt(acc_sum);
                MET_DOT, MET_L2SQ: r = acc_sum;
                default: r = one_minus(fp_div(acc_sum,
                                              fp_mul(qnorm, fp_sqrt(ysq_sum))));
            endcase
            if (is_nan(r)) r = QNAN;
            result_q.push_back(r);
            acc_sum = FP_ZERO;
            ysq_sum = FP_ZERO;
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
                return;
            end
            want = result_q.pop_front();
            results_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h, got %h", want, got);
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    dist_scoreboard sb;
    bit quiet;
    int vectors_sent;
    int metric_hits[4];
    longint cycles;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (quiet) return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_result(o_m_tdata);
        end
    end

    task automatic send_elem(logic [15:0] xe, logic [15:0] ye, logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {ye, xe};
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(xe, ye, last);
        if (last) vectors_sent++;
        if (last) metric_hits[sb.metric]++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic idx, logic [31:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_bf16();
        logic [15:0] specials[10];
        specials = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0,
                     16'hFFFF, 16'h0001, 16'h807F, 16'h7F7F, 16'hFF7F};
        case ($urandom_range(0, 15))
            0: return 16'($urandom);
            1: return specials[$urandom_range(0, 9)];
            default: return {1'($urandom), 8'($urandom_range(118, 136)),
                             7'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_qnorm();
        case ($urandom_range(0, 7))
            0: return FP_ZERO;
            1: return 32'h7F80_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom;
            4: return FP_ONE;
            default: return {1'b0, 8'($urandom_range(120, 134)), 23'($urandom)};
        endcase
    endfunction

    initial begin
        int len;
        int nvec;
        sb = new();
        quiet = 1'b0;
        vectors_sent = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 32'd0;
        i_s_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_METRIC;
        i_cfg_data = 32'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: norm of x with unit query norm
        send_elem(16'h3F80, 16'h1234, 1'b1);
        send_elem(16'h7F7F, 16'h0000, 1'b1);
        send_elem(16'h0001, 16'hFFFF, 1'b1);
        send_elem(16'h8000, 16'h0000, 1'b0);
        send_elem(16'h4080, 16'h0000, 1'b1);
        set_reg(CFG_METRIC, 32'(MET_DOT));
        send_elem(16'h7F80, 16'h0000, 1'b1);
        send_elem(16'h7F7F, 16'h7F7F, 1'b0);
        send_elem(16'hFF7F, 16'h7F7F, 1'b1);
        send_elem(16'hFFFF, 16'h0001, 1'b1);
        set_reg(CFG_METRIC, 32'(MET_L2SQ));
        send_elem(16'h7FC0, 16'h3F80, 1'b1);
        send_elem(16'h3F80, 16'h3F80, 1'b1);
        send_elem(16'h0080, 16'h8080, 1'b1);
        // partial vector carried into the next metric
        send_elem(16'h4000, 16'h3F80, 1'b0);
        set_reg(CFG_METRIC, 32'(MET_COS));
        set_reg(CFG_QNORM, FP_ZERO);
        send_elem(16'h3F80, 16'h3F80, 1'b1);
        set_reg(CFG_QNORM, 32'hFFFF_FFFF);
        send_elem(16'h4000, 16'h4000, 1'b1);
        set_reg(CFG_QNORM, FP_ONE);
        send_elem(16'h0000, 16'h0000, 1'b1);
        send_elem(16'h3F80, 16'hBF80, 1'b1);

        while (sb.items_in < TARGET_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            set_reg(CFG_METRIC, 32'($urandom_range(0, 3)));
            if (sb.metric == MET_COS || $urandom_range(0, 3) == 0)
                set_reg(CFG_QNORM, rand_qnorm());
            nvec = $urandom_range(10, 30);
            for (int v = 0; v < nvec; v++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_elem(rand_bf16(), rand_bf16(), k == len - 1);
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) send_elem(rand_bf16(), rand_bf16(), 1'b0);
            end
        end

        drain();
        $display("sent %0d elements in %0d vectors, checked %0d results",
                 sb.items_in, vectors_sent, sb.results_checked);
        $display("vectors per metric: norm %0d dot %0d l2sq %0d cosine %0d",
                 metric_hits[0], metric_hits[1], metric_hits[2], metric_hits[3]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("mismatches: %0d, outstanding: %0d", sb.mismatches, sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
